### hdl/bounded_ordered_list_buffer_top_macros.svh
// Assertion macros shared by the list buffer RTL.
`ifndef BOUNDED_ORDERED_LIST_BUFFER_TOP_MACROS_SVH
`define BOUNDED_ORDERED_LIST_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define BOLB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bolb: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define BOLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bolb: next-cycle check failed");

`endif

### hdl/bolb_pkg.sv
// Package: commands, status codes, cell controls and fixed port widths of the list buffer.
package bolb_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int COMMAND_W  = 3;
  localparam int POSITION_W = 5;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 5;
  localparam int STATUS_W   = 2;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_PUSH_TAIL = 3'd0,
    CMD_POP_TAIL  = 3'd1,
    CMD_PUSH_HEAD = 3'd2,
    CMD_POP_HEAD  = 3'd3,
    CMD_INSERT    = 3'd4,
    CMD_ERASE     = 3'd5,
    CMD_READ      = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell does this cycle, relative to the broadcast position.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,  // above pos take left neighbor, at pos load value
    CELL_CLOSE = 2'd2   // at and above pos take right neighbor
  } cell_op_t;

  typedef struct packed {
    cell_op_t cell_op;
    status_t  status;
    logic     rd_en;
  } ctrl_res_t;

endpackage

### hdl/bolb_cell.sv
// One storage cell of the list: holds a word, shifts from either neighbor or loads.
module bolb_cell #(
  parameter int WORD_WIDTH = bolb_pkg::WORD_WIDTH_DEF,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  bolb_pkg::cell_op_t    op,
  input  logic [IDX_W-1:0]      pos,
  input  logic [WORD_WIDTH-1:0] load_word,
  input  logic [WORD_WIDTH-1:0] left_word,
  input  logic [WORD_WIDTH-1:0] right_word,
  output logic [WORD_WIDTH-1:0] word_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (op)
      bolb_pkg::CELL_OPEN: begin
        if (MY_IDX > pos) begin
          word_nxt = left_word;
        end else if (MY_IDX == pos) begin
          word_nxt = load_word;
        end
      end
      bolb_pkg::CELL_CLOSE: begin
        if (MY_IDX >= pos) begin
          word_nxt = right_word;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

### hdl/bolb_ctrl.sv
// Command decode, range/full checks and the element count register.
module bolb_ctrl #(
  parameter int DEPTH = bolb_pkg::DEPTH_DEF,
  parameter int CNT_W = 5,
  parameter int IDX_W = 4,
  parameter int CMP_W = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [bolb_pkg::COMMAND_W-1:0]  command,
  input  logic [bolb_pkg::POSITION_W-1:0] position,
  output bolb_pkg::ctrl_res_t             res,
  output logic [IDX_W-1:0]                cell_pos,
  output logic [CNT_W-1:0]                count_nxt,
  output logic [CNT_W-1:0]                count_q
);

  logic [CNT_W-1:0] count_r;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic             full;
  logic             empty;
  bolb_pkg::cmd_t   cmd;
  bolb_pkg::cell_op_t op_dec;

  assign cmd   = bolb_pkg::cmd_t'(command);
  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(count_r);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    op_dec     = bolb_pkg::CELL_HOLD;
    res.status = bolb_pkg::ST_OK;
    res.rd_en  = 1'b0;
    cell_pos   = pos_c[IDX_W-1:0];
    count_nxt  = count_r;
    case (cmd)
      bolb_pkg::CMD_PUSH_TAIL: begin
        cell_pos = count_r[IDX_W-1:0];
        if (full) begin
          res.status = bolb_pkg::ST_FULL;
        end else begin
          op_dec    = bolb_pkg::CELL_OPEN;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      bolb_pkg::CMD_POP_TAIL: begin
        if (empty) begin
          res.status = bolb_pkg::ST_RANGE;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      bolb_pkg::CMD_PUSH_HEAD: begin
        cell_pos = '0;
        if (full) begin
          res.status = bolb_pkg::ST_FULL;
        end else begin
          op_dec    = bolb_pkg::CELL_OPEN;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      bolb_pkg::CMD_POP_HEAD: begin
        cell_pos = '0;
        if (empty) begin
          res.status = bolb_pkg::ST_RANGE;
        end else begin
          op_dec    = bolb_pkg::CELL_CLOSE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      bolb_pkg::CMD_INSERT: begin
        // range is checked before fullness
        if (pos_c > cnt_c) begin
          res.status = bolb_pkg::ST_RANGE;
        end else if (full) begin
          res.status = bolb_pkg::ST_FULL;
        end else begin
          op_dec    = bolb_pkg::CELL_OPEN;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      bolb_pkg::CMD_ERASE: begin
        if (pos_c >= cnt_c) begin
          res.status = bolb_pkg::ST_RANGE;
        end else begin
          op_dec    = bolb_pkg::CELL_CLOSE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      bolb_pkg::CMD_READ: begin
        if (pos_c >= cnt_c) begin
          res.status = bolb_pkg::ST_RANGE;
        end else begin
          res.rd_en = 1'b1;
        end
      end
      bolb_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    // cells only move on an accepted item
    res.cell_op = accept ? op_dec : bolb_pkg::CELL_HOLD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  assign count_q = count_r;

endmodule

### hdl/bounded_ordered_list_buffer_top.sv
// Top level of the bounded ordered list buffer: cell chain, control and output register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in_     | input     | in_valid / in_stall  | in_command, in_position, in_value
//  out_    | output    | out_valid / out_stall| out_read_value, out_count, out_status
//
// One item is taken per clock while in_stall is low, and its result
// appears in the output register on the next cycle.
// Insert and erase shift all affected cells in the same cycle, each cell taking its
// word from its left or right neighbor.
// Reset (rst_n low, synchronous) empties the list; cell contents are not cleared.
// in_stall is high only while a finished result sits in the output register and the
// downstream side stalls it; otherwise a new item is taken every cycle.
`include "bounded_ordered_list_buffer_top_macros.svh"

module bounded_ordered_list_buffer_top #(
  parameter int DEPTH      = bolb_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = bolb_pkg::WORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bolb_pkg::COMMAND_W-1:0]  in_command,
  input  logic [bolb_pkg::POSITION_W-1:0] in_position,
  input  logic [bolb_pkg::VALUE_W-1:0]    in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bolb_pkg::VALUE_W-1:0]    out_read_value,
  output logic [bolb_pkg::COUNT_W-1:0]    out_count,
  output logic [bolb_pkg::STATUS_W-1:0]   out_status
);

  // count holds 0..DEPTH; compares run wide enough for both count and position
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > bolb_pkg::POSITION_W) ? CNT_W : bolb_pkg::POSITION_W;

  logic                  accept;
  bolb_pkg::ctrl_res_t   res;
  logic [IDX_W-1:0]      cell_pos;
  logic [CNT_W-1:0]      count_nxt;
  logic [CNT_W-1:0]      count_q;
  logic [WORD_WIDTH-1:0] load_word;
  logic [63:0]           value_ext;
  logic [63:0]           rd_ext;
  logic [CMP_W-1:0]      count_ext;
  logic [WORD_WIDTH-1:0] cell_word [DEPTH];

  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [bolb_pkg::VALUE_W-1:0]       out_read_value_r;
  logic [bolb_pkg::VALUE_W-1:0]       out_read_value_nxt;
  logic [bolb_pkg::COUNT_W-1:0]       out_count_r;
  bolb_pkg::status_t                  out_status_r;

  // Handshake: a result stalled in the output register blocks the input.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Stored words keep WORD_WIDTH bits of the item's value.
  assign value_ext = 64'(in_value);
  assign load_word = value_ext[WORD_WIDTH-1:0];

  bolb_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W),
    .CMP_W (CMP_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .command   (in_command),
    .position  (in_position),
    .res       (res),
    .cell_pos  (cell_pos),
    .count_nxt (count_nxt),
    .count_q   (count_q)
  );

  // Cell chain. Ends see zero from outside; those words are never kept in a live slot.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;

    if (gi == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_word[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[gi+1];
    end

    bolb_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (gi)
    ) u_cell (
      .clk        (clk),
      .op         (res.cell_op),
      .pos        (cell_pos),
      .load_word  (load_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word_q     (cell_word[gi])
    );
  end

  // Read value only for a successful read; zero otherwise.
  assign rd_ext             = 64'(cell_word[cell_pos]);
  assign out_read_value_nxt = res.rd_en ? rd_ext[bolb_pkg::VALUE_W-1:0] : '0;
  assign count_ext          = CMP_W'(count_nxt);

  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value_r <= out_read_value_nxt;
      out_count_r      <= count_ext[bolb_pkg::COUNT_W-1:0];
      out_status_r     <= res.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

  // Checks
  `BOLB_ASSERT_NOW(a_count_bounded, clk, rst_n, 1'b1, count_q <= CNT_W'(DEPTH))
  `BOLB_ASSERT_NEXT(a_refused_keeps_count, clk, rst_n, accept && res.status != bolb_pkg::ST_OK, count_q == $past(count_q))
  `BOLB_ASSERT_NEXT(a_idle_keeps_count, clk, rst_n, !accept, count_q == $past(count_q))
  `BOLB_ASSERT_NOW(a_error_reads_zero, clk, rst_n, out_valid_r && out_status_r != bolb_pkg::ST_OK, out_read_value_r == '0)

endmodule
